### sv/psfe_pkg.sv
// ============================================================================
// psfe_pkg
// Shared constants and types of the PCM sample format encoder: format codes,
// G.711 segment limits and the result word that passes between modules.
// ============================================================================
`default_nettype none

package psfe_pkg;

    localparam int SAMPLE_W = 16;
    localparam int BYTE_W   = 8;
    localparam int FMT_W    = 4;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Output format codes.
    localparam logic [FMT_W-1:0] FMT_MULAW = 4'd0;
    localparam logic [FMT_W-1:0] FMT_ALAW  = 4'd1;
    localparam logic [FMT_W-1:0] FMT_ADPCM = 4'd2;
    localparam logic [FMT_W-1:0] FMT_U8    = 4'd3;
    localparam logic [FMT_W-1:0] FMT_S16LE = 4'd4;
    localparam logic [FMT_W-1:0] FMT_S16BE = 4'd5;
    localparam logic [FMT_W-1:0] FMT_U16LE = 4'd6;
    localparam logic [FMT_W-1:0] FMT_U16BE = 4'd7;

    // Register index of the format register.
    localparam logic REG_OUTPUT_FORMAT = 1'b0;

    // Segment upper limits for mu-law (14-bit magnitude) and A-law (12-bit).
    localparam logic [13:0] MU_SEG_END [0:7] = '{
        14'h003F, 14'h007F, 14'h00FF, 14'h01FF,
        14'h03FF, 14'h07FF, 14'h0FFF, 14'h1FFF
    };
    localparam logic [11:0] A_SEG_END [0:7] = '{
        12'h01F, 12'h03F, 12'h07F, 12'h0FF,
        12'h1FF, 12'h3FF, 12'h7FF, 12'hFFF
    };

    localparam logic [13:0] MU_CLIP = 14'd8159;
    localparam logic [13:0] MU_BIAS = 14'd33;

    typedef struct packed {
        logic [BYTE_W-1:0] first_byte;
        logic [BYTE_W-1:0] second_byte;
        logic [1:0]        byte_count;
        logic              unsupported;
    } enc_res_t;

endpackage

`default_nettype wire

### sv/psfe_apb_regs.sv
// ============================================================================
// psfe_apb_regs
// APB register block holding the output format register.
// ============================================================================
`default_nettype none

module psfe_apb_regs
    import psfe_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output logic      [FMT_W-1:0]   fmt
);

    logic [FMT_W-1:0] fmt_reg;
    logic [FMT_W-1:0] fmt_next;
    logic             reg_sel;
    logic             wr_en;

    // Registers sit on 4-byte boundaries; bit 2 selects the register index.
    assign reg_sel = (paddr[2] == REG_OUTPUT_FORMAT);
    assign wr_en   = psel && penable && pwrite && reg_sel;
    assign pready  = 1'b1;

    always_comb
    begin
        fmt_next = fmt_reg;
        if (wr_en)
        begin
            fmt_next = pwdata[FMT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_S16LE;
        end
        else
        begin
            fmt_reg <= fmt_next;
        end
    end

    assign prdata = reg_sel ? {{(PDATA_W-FMT_W){1'b0}}, fmt_reg} : '0;
    assign fmt    = fmt_reg;

endmodule

`default_nettype wire

### sv/psfe_encoder.sv
// ============================================================================
// psfe_encoder
// Combinational encoder: turns one 16-bit sample into the byte layout of the
// selected format (G.711 mu-law/A-law, u8, 16-bit orders, ADPCM as zero byte).
// ============================================================================
`default_nettype none

module psfe_encoder
    import psfe_pkg::*;
(
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic        [FMT_W-1:0]    fmt,
    output enc_res_t                        res
);

    function automatic logic [3:0] mu_segment(input logic [13:0] val);
        logic [3:0] seg;
        seg = 4'd8;
        for (int i = 7; i >= 0; i--)
        begin
            if (val <= MU_SEG_END[i])
            begin
                seg = 4'(i);
            end
        end
        return seg;
    endfunction

    function automatic logic [3:0] a_segment(input logic [11:0] val);
        logic [3:0] seg;
        seg = 4'd8;
        for (int i = 7; i >= 0; i--)
        begin
            if (val <= A_SEG_END[i])
            begin
                seg = 4'(i);
            end
        end
        return seg;
    endfunction

    function automatic logic [7:0] encode_mulaw(input logic signed [15:0] s);
        logic signed [13:0] v;
        logic [13:0]        mag;
        logic [7:0]         mask;
        logic [3:0]         seg;
        logic [13:0]        shifted;
        logic [7:0]         code;
        v = s[15:2];
        if (v[13])
        begin
            mag  = 14'(-v);
            mask = 8'h7F;
        end
        else
        begin
            mag  = v;
            mask = 8'hFF;
        end
        if (mag > MU_CLIP)
        begin
            mag = MU_CLIP;
        end
        mag = mag + MU_BIAS;
        seg = mu_segment(mag);
        shifted = mag >> (seg + 4'd1);
        if (seg[3])
        begin
            code = 8'h7F ^ mask;
        end
        else
        begin
            code = {1'b0, seg[2:0], shifted[3:0]} ^ mask;
        end
        return code;
    endfunction

    function automatic logic [7:0] encode_alaw(input logic signed [15:0] s);
        logic signed [12:0] v;
        logic [11:0]        mag;
        logic [7:0]         mask;
        logic [3:0]         seg;
        logic [11:0]        shifted;
        logic [7:0]         code;
        v = s[15:3];
        if (!v[12])
        begin
            mag  = v[11:0];
            mask = 8'hD5;
        end
        else
        begin
            // -v - 1 is the bitwise complement.
            mag  = ~v[11:0];
            mask = 8'h55;
        end
        seg = a_segment(mag);
        if (seg < 4'd2)
        begin
            shifted = mag >> 1;
        end
        else
        begin
            shifted = mag >> seg;
        end
        if (seg[3])
        begin
            code = 8'h7F ^ mask;
        end
        else
        begin
            code = {1'b0, seg[2:0], shifted[3:0]} ^ mask;
        end
        return code;
    endfunction

    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] u8_q;
    logic [7:0] mu_byte;
    logic [7:0] a_byte;

    assign lo = sample[7:0];
    assign hi = sample[15:8];

    // Division by 256 toward zero: round the floored value up for negative
    // samples with a nonzero remainder. Adding 128 flips the top bit.
    assign u8_q = hi + {7'd0, (sample[15] && (lo != 8'd0))};

    assign mu_byte = encode_mulaw(sample);
    assign a_byte  = encode_alaw(sample);

    always_comb
    begin
        res = '0;
        unique case (fmt)
            FMT_MULAW:
            begin
                res.first_byte = mu_byte;
                res.byte_count = 2'd1;
            end
            FMT_ALAW:
            begin
                res.first_byte = a_byte;
                res.byte_count = 2'd1;
            end
            FMT_ADPCM:
            begin
                res.byte_count = 2'd1;
            end
            FMT_U8:
            begin
                res.first_byte = u8_q ^ 8'h80;
                res.byte_count = 2'd1;
            end
            FMT_S16LE:
            begin
                res.first_byte  = lo;
                res.second_byte = hi;
                res.byte_count  = 2'd2;
            end
            FMT_S16BE:
            begin
                res.first_byte  = hi;
                res.second_byte = lo;
                res.byte_count  = 2'd2;
            end
            FMT_U16LE:
            begin
                res.first_byte  = lo;
                res.second_byte = hi ^ 8'h80;
                res.byte_count  = 2'd2;
            end
            FMT_U16BE:
            begin
                res.first_byte  = hi ^ 8'h80;
                res.second_byte = lo;
                res.byte_count  = 2'd2;
            end
            default:
            begin
                res.unsupported = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/pcm_sample_format_encoder.sv
// ============================================================================
// pcm_sample_format_encoder
// Encodes one signed 16-bit PCM sample per word into the configured output
// format: input register, combinational encoder, result register.
// ============================================================================
//
//  Channel   Handshake             Payload
//  -------   --------------------  ---------------------------------------------
//  input     in_valid / in_ready   sample
//  output    out_valid / out_ready first_byte, second_byte, byte_count, unsupported
//  config    APB (psel, penable)   paddr, pwdata, prdata
//
//  One word is accepted per clock while in_ready is high; each word passes
//  through the input register, then the result register.
//  A single combinational encoder sits between the two registers.
//  A stall on out_ready holds the result register and backs up the input
//  register; in_ready drops only when both are full and the output is stalled.
//  rst_n clears both valid flags and sets the format to s16le.
//
`default_nettype none

module pcm_sample_format_encoder
    import psfe_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic        [PADDR_W-1:0]  paddr,
    input  wire logic        [PDATA_W-1:0]  pwdata,
    output logic             [PDATA_W-1:0]  prdata,
    output logic                            pready,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic             [BYTE_W-1:0]   first_byte,
    output logic             [BYTE_W-1:0]   second_byte,
    output logic             [1:0]          byte_count,
    output logic                            unsupported
);

    logic [FMT_W-1:0] fmt;

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] sample_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    enc_res_t                   res_reg;
    enc_res_t                   res_next;
    enc_res_t                   enc_res;

    logic out_load;
    logic in_load;

    psfe_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .fmt     (fmt)
    );

    psfe_encoder u_enc (
        .sample (sample_reg),
        .fmt    (fmt),
        .res    (enc_res)
    );

    // The result register can load when it is empty or being drained.
    assign out_load = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || out_load;
    assign in_load  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        sample_next    = sample_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        if (out_load)
        begin
            out_valid_next = s1_valid_reg;
            res_next       = enc_res;
        end
        if (in_ready)
        begin
            s1_valid_next = in_valid;
        end
        if (in_load)
        begin
            sample_next = sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        res_reg    <= res_next;
    end

    assign out_valid   = out_valid_reg;
    assign first_byte  = res_reg.first_byte;
    assign second_byte = res_reg.second_byte;
    assign byte_count  = res_reg.byte_count;
    assign unsupported = res_reg.unsupported;

    a_unsup_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.unsupported |->
            res_reg.byte_count == 2'd0 && res_reg.first_byte == 8'd0)
        else $error("unsupported result carries bytes");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> res_reg.byte_count != 2'd3)
        else $error("byte count out of range");

    a_one_byte_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.byte_count != 2'd2 |-> res_reg.second_byte == 8'd0)
        else $error("second byte set for a one-byte format");

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_load |=> s1_valid_reg && sample_reg == $past(sample))
        else $error("accepted word not captured");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_load |=> s1_valid_reg && $stable(sample_reg))
        else $error("stalled input register changed");

endmodule

`default_nettype wire
